>>> rtl/pnps_pkg.sv
// ----------------------------------------------------------------------------
// pnps_pkg
// Shared types and constants for the packed 4-bit pixel store.
// ----------------------------------------------------------------------------
package pnps_pkg;

	localparam int COORD_W   = 16;
	localparam int PIX_W     = 4;
	localparam int FRM_W_W   = 9;
	localparam int FRM_H_W   = 7;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int PROD_W    = FRM_W_W + FRM_H_W;

	localparam logic [FRM_W_W-1:0] WIDTH_RST  = 9'd256;
	localparam logic [FRM_H_W-1:0] HEIGHT_RST = 7'd64;

	// register index, taken from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FILL  = 2'd2
	} op_t;

	typedef struct packed {
		logic load_item;
		logic calc;
		logic mem_rd;
		logic rmw_wr;
		logic out_load;
		logic sweep_init;
		logic sweep_clear;
		logic sweep_step;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       sweep_done;
		logic       out_free;
	} dp_status_t;

endpackage

>>> rtl/packed_nibble_pixel_store.sv
// ----------------------------------------------------------------------------
// packed_nibble_pixel_store
// 4-bit grayscale frame store, two pixels per byte, with read, nibble write
// and whole-frame fill.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one operation per transfer:
//   mode 0 reads the pixel at (coord_x, coord_y), mode 1 writes pixel_value
//   there, mode 2 fills the used part of the frame with pixel_value, mode 3
//   is dropped. Only reads produce a transfer on the output channel
//   (out_valid/out_stall, read_value); out-of-range reads return zero.
//   Frame size is set over the APB port: frame_width at 0x0, frame_height
//   at 0x4; write them only while the block is idle.
//   Sequence: one item at a time through accept, index calc, store read and
//   merge/result steps; a new item is taken only when the last one is done.
//   A fill writes min(ceil(width*height/2), STORE_BYTES) bytes through the
//   single store write port, sweeping one byte per cycle. Mode 3 returns to
//   idle after the index calc step.
//   Reset: the store is swept to zero with in_stall high throughout. A stalled
//   result stays in the output register; a read behind it waits in the final
//   step until that register frees up.
// ----------------------------------------------------------------------------
module packed_nibble_pixel_store #(
	parameter int unsigned STORE_BYTES = 8192
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pnps_pkg::PADDR_W-1:0]         paddr,
	input  logic [pnps_pkg::PDATA_W-1:0]         pwdata,
	output logic [pnps_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           mode,
	input  logic signed [pnps_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [pnps_pkg::COORD_W-1:0]  coord_y,
	input  logic [pnps_pkg::PIX_W-1:0]           pixel_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pnps_pkg::PIX_W-1:0]           read_value
);

	logic [pnps_pkg::FRM_W_W-1:0] frame_width_q;
	logic [pnps_pkg::FRM_H_W-1:0] frame_height_q;
	logic                         reg_sel;
	logic                         cfg_wr;

	assign pready  = 1'b1;
	// byte lanes are ignored; the word select picks the register
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= pnps_pkg::WIDTH_RST;
			frame_height_q <= pnps_pkg::HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				pnps_pkg::REG_WIDTH:  frame_width_q  <= pwdata[pnps_pkg::FRM_W_W-1:0];
				pnps_pkg::REG_HEIGHT: frame_height_q <= pwdata[pnps_pkg::FRM_H_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			pnps_pkg::REG_WIDTH:  prdata = {23'd0, frame_width_q};
			pnps_pkg::REG_HEIGHT: prdata = {25'd0, frame_height_q};
			default:              prdata = '0;
		endcase
	end

	pnps_pkg::dp_cmd_t    cmd;
	pnps_pkg::dp_status_t status;

	pnps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pnps_dpath #(
		.STORE_BYTES (STORE_BYTES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.mode         (mode),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.pixel_value  (pixel_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_value   (read_value)
	);

`ifndef SYNTH
	// one item in flight: intake closes right after a transfer
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an item is in flight");

	// a result never overwrites one the receiver has not taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	// the sweep never writes at or past its limit
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_step |-> !status.sweep_done)
		else $error("sweep write past limit");

	// store writes from the sweep and the merge never collide
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sweep_step && (cmd.rmw_wr || cmd.mem_rd || cmd.load_item)))
		else $error("sweep overlaps item traffic");
`endif

endmodule

>>> rtl/pnps_ctrl.sv
// ----------------------------------------------------------------------------
// pnps_ctrl
// Sequencer: item intake, index calc, nibble read-modify-write, fill sweep.
// ----------------------------------------------------------------------------
module pnps_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pnps_pkg::dp_status_t  status,
	output pnps_pkg::dp_cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_CALC,
		S_RD,
		S_DONE,
		S_FILL,
		S_SWEEP
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				// power-up clearing pass over the whole store
				cmd.sweep_init  = 1'b1;
				cmd.sweep_clear = 1'b1;
				state_d         = S_SWEEP;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				case (status.mode) inside
					pnps_pkg::OP_READ, pnps_pkg::OP_WRITE: state_d = S_RD;
					pnps_pkg::OP_FILL:                     state_d = S_FILL;
					default:                               state_d = S_IDLE;
				endcase
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (status.mode == pnps_pkg::OP_READ) begin
					// hold here until the output register can take the result
					if (status.out_free) begin
						cmd.out_load = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.rmw_wr = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_FILL: begin
				cmd.sweep_init = 1'b1;
				state_d        = S_SWEEP;
			end
			S_SWEEP: begin
				if (status.sweep_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.sweep_step = 1'b1;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/pnps_dpath.sv
// ----------------------------------------------------------------------------
// pnps_dpath
// Item registers, pixel index and bounds logic, byte store, sweep counter
// and the result register.
// ----------------------------------------------------------------------------
module pnps_dpath #(
	parameter int unsigned STORE_BYTES = 8192
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pnps_pkg::dp_cmd_t                    cmd,
	output pnps_pkg::dp_status_t                 status,
	input  logic [pnps_pkg::FRM_W_W-1:0]         frame_width,
	input  logic [pnps_pkg::FRM_H_W-1:0]         frame_height,
	input  logic [1:0]                           mode,
	input  logic signed [pnps_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [pnps_pkg::COORD_W-1:0]  coord_y,
	input  logic [pnps_pkg::PIX_W-1:0]           pixel_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pnps_pkg::PIX_W-1:0]           read_value
);

	localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int CNT_W  = $clog2(STORE_BYTES + 1);
	localparam int IDX_W  = pnps_pkg::PROD_W + 1;
	localparam logic [IDX_W-1:0] STORE_LIM = IDX_W'(STORE_BYTES);

	// item registers
	logic [1:0]                          mode_q;
	logic signed [pnps_pkg::COORD_W-1:0] coord_x_q;
	logic signed [pnps_pkg::COORD_W-1:0] coord_y_q;
	logic [pnps_pkg::PIX_W-1:0]          pixel_value_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q        <= mode;
			coord_x_q     <= coord_x;
			coord_y_q     <= coord_y;
			pixel_value_q <= pixel_value;
		end
	end

	// index and bounds
	logic                          x_ok_c;
	logic                          y_ok_c;
	logic [pnps_pkg::PROD_W-1:0]   pix_c;
	logic [IDX_W-1:0]              byte_c;
	logic                          in_store_c;
	logic                          hit_q;
	logic                          odd_q;
	logic [ADDR_W-1:0]             addr_q;
	logic [pnps_pkg::PROD_W-1:0]   prod_q;

	always_comb begin
		x_ok_c = !coord_x_q[pnps_pkg::COORD_W-1]
			&& ($unsigned(coord_x_q) < {7'd0, frame_width});
		y_ok_c = !coord_y_q[pnps_pkg::COORD_W-1]
			&& ($unsigned(coord_y_q) < {9'd0, frame_height});
		// only meaningful when both coordinates are in range
		pix_c = pnps_pkg::PROD_W'({9'd0, coord_y_q[pnps_pkg::FRM_H_W-1:0]}
			* {7'd0, frame_width}) + {7'd0, coord_x_q[pnps_pkg::FRM_W_W-1:0]};
		byte_c     = {2'b00, pix_c[pnps_pkg::PROD_W-1:1]};
		in_store_c = (byte_c < STORE_LIM);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			hit_q  <= x_ok_c && y_ok_c && in_store_c;
			odd_q  <= pix_c[0];
			addr_q <= byte_c[ADDR_W-1:0];
			prod_q <= pnps_pkg::PROD_W'({7'd0, frame_width} * {9'd0, frame_height});
		end
	end

	// fill / clear sweep
	logic [IDX_W-1:0] used_c;
	logic [IDX_W-1:0] fill_lim_c;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] lim_q;
	logic [7:0]       fill_byte_q;

	always_comb begin
		used_c     = ({1'b0, prod_q} + IDX_W'(1)) >> 1;
		fill_lim_c = (used_c > STORE_LIM) ? STORE_LIM : used_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lim_q <= '0;
		end else if (cmd.sweep_init) begin
			cnt_q <= '0;
			lim_q <= cmd.sweep_clear ? CNT_W'(STORE_BYTES) : fill_lim_c[CNT_W-1:0];
		end else if (cmd.sweep_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_init) begin
			fill_byte_q <= cmd.sweep_clear ? 8'h00 : {pixel_value_q, pixel_value_q};
		end
	end

	// byte store
	logic [7:0]        mem [STORE_BYTES];
	logic [7:0]        rd_data_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic [7:0]        merged;

	always_comb begin
		// even pixel in the high nibble, odd pixel in the low nibble
		merged    = odd_q ? {rd_data_q[7:4], pixel_value_q}
		                  : {pixel_value_q, rd_data_q[3:0]};
		mem_we    = cmd.sweep_step || (cmd.rmw_wr && hit_q);
		mem_waddr = cmd.sweep_step ? cnt_q[ADDR_W-1:0] : addr_q;
		mem_wdata = cmd.sweep_step ? fill_byte_q : merged;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.mem_rd) begin
			rd_data_q <= mem[addr_q];
		end
	end

	// result register
	logic                       out_valid_q;
	logic [pnps_pkg::PIX_W-1:0] read_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_value_q <= !hit_q ? '0 : (odd_q ? rd_data_q[3:0] : rd_data_q[7:4]);
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;

	assign status.mode       = mode_q;
	assign status.sweep_done = (cnt_q == lim_q);
	assign status.out_free   = !out_valid_q || !out_stall;

endmodule
